### sv/mme_pkg.sv
// shared types, constants and helpers of the matrix multiply engine
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package mme_pkg;

   // default for the largest matrix dimension
   localparam int MAX_DIM_DEF = 8;

   // field widths
   localparam int TYPE_W  = 2;
   localparam int IDX_W   = 3;
   localparam int ELEM_W  = 32;
   localparam int SIZE_W  = 4;
   localparam int VALUE_W = 64;

   // stream word widths, fields packed from bit 0 and padded to bytes
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 72;

   // configuration port
   localparam int CSR_IDX_W = 2;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_LOAD_A  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_LOAD_B  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_COMPUTE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_ROWS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_COLS   = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   // commands from the controller to the datapath
   typedef struct packed {
      logic             wr_a;
      logic             wr_b;
      logic [IDX_W-1:0] wr_row;
      logic [IDX_W-1:0] wr_col;
      logic             rd_en;
      logic [IDX_W-1:0] rd_row;
      logic [IDX_W-1:0] rd_inner;
      logic [IDX_W-1:0] rd_col;
      logic             acc_clear;
      logic             out_load;
      logic             out_last;
   } mme_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic out_free;
   } mme_sts_type;

   // zero acts as one, anything above the largest dimension as the largest
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                  input logic [SIZE_W-1:0] max_dim);
      logic [SIZE_W-1:0] e;
      if (r == '0) begin
         e = SIZE_W'(1);
      end else if (r > max_dim) begin
         e = max_dim;
      end else begin
         e = r;
      end
      return e;
   endfunction

endpackage

`default_nettype wire

### sv/mme_ctrl.sv
// controller of the matrix multiply engine: size registers, load decode,
// and the row / column / inner loop sequencer; uses mme_pkg
`default_nettype none

module mme_ctrl #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [mme_pkg::TYPE_W-1:0]     req_type,
   input  wire logic [mme_pkg::IDX_W-1:0]      req_row,
   input  wire logic [mme_pkg::IDX_W-1:0]      req_col,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [mme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mme_pkg::SIZE_W-1:0]     csr_data,
   output mme_pkg::mme_cmd_type                cmd,
   input  wire mme_pkg::mme_sts_type           sts
);
   import mme_pkg::*;

   localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIM);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [SIZE_W-1:0] rows_ff, rows_in;
   logic [SIZE_W-1:0] inner_ff, inner_in;
   logic [SIZE_W-1:0] cols_ff, cols_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic              drain_ff, drain_in;

   logic [SIZE_W-1:0] nr, ni, nc;
   logic              k_last, j_last, i_last;
   logic              req_acc;

   assign nr = eff_size(rows_ff, MAX_SIZE);
   assign ni = eff_size(inner_ff, MAX_SIZE);
   assign nc = eff_size(cols_ff, MAX_SIZE);

   assign k_last = (SIZE_W'(k_ff) == ni - SIZE_W'(1));
   assign j_last = (SIZE_W'(j_ff) == nc - SIZE_W'(1));
   assign i_last = (SIZE_W'(i_ff) == nr - SIZE_W'(1));

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_acc    = req_tvalid && req_tready;

   // size registers
   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OUT_ROWS:   rows_in  = csr_data;
            CSR_INNER_SIZE: inner_in = csr_data;
            CSR_OUT_COLS:   cols_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      drain_in = drain_ff;

      cmd           = '0;
      cmd.wr_row    = req_row;
      cmd.wr_col    = req_col;
      cmd.rd_row    = IDX_W'(i_ff);
      cmd.rd_inner  = IDX_W'(k_ff);
      cmd.rd_col    = IDX_W'(j_ff);
      cmd.out_last  = i_last && j_last;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_type)
                  REQ_LOAD_A: begin
                     cmd.wr_a = ({1'b0, req_row} < nr) && ({1'b0, req_col} < ni);
                  end
                  REQ_LOAD_B: begin
                     cmd.wr_b = ({1'b0, req_row} < ni) && ({1'b0, req_col} < nc);
                  end
                  REQ_COMPUTE: begin
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                     state_in = ST_MAC;
                  end
                  default: ;
               endcase
            end
         end
         ST_MAC: begin
            cmd.rd_en     = 1'b1;
            cmd.acc_clear = (k_ff == '0);
            if (k_last) begin
               k_in     = '0;
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            // read and multiply stages still in flight
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (i_last && j_last) begin
                  state_in = ST_IDLE;
               end else if (j_last) begin
                  j_in     = '0;
                  i_in     = i_ff + CNT_W'(1);
                  state_in = ST_MAC;
               end else begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_MAC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= SIZE_RESET;
         inner_ff <= SIZE_RESET;
         cols_ff  <= SIZE_RESET;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         drain_ff <= drain_in;
      end
   end

endmodule

`default_nettype wire

### sv/mme_dpath.sv
// datapath of the matrix multiply engine: the two element stores, the
// multiply-accumulate pipe, saturation and the result register; uses mme_pkg
`default_nettype none

module mme_dpath #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire mme_pkg::mme_cmd_type             cmd,
   output mme_pkg::mme_sts_type                  sts,
   input  wire logic [mme_pkg::ELEM_W-1:0]       wr_value,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [mme_pkg::IDX_W-1:0]             rsp_row,
   output logic [mme_pkg::IDX_W-1:0]             rsp_col,
   output logic [mme_pkg::VALUE_W-1:0]           rsp_value,
   output logic                                  rsp_tlast
);
   import mme_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CALC_W = 2 * IDX_W + 1;
   localparam int ACC_W  = VALUE_W + $clog2(MAX_DIM) + 1;

   logic [ELEM_W-1:0] a_mem [DEPTH];
   logic [ELEM_W-1:0] b_mem [DEPTH];

   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

   logic signed [ELEM_W-1:0]  a_ff, b_ff;
   logic                      rd_vld_ff;
   logic signed [VALUE_W-1:0] prod_ff;
   logic                      prod_vld_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [VALUE_W-1:0]        sat_value;

   logic                      out_vld_ff;
   logic [IDX_W-1:0]          out_row_ff, out_col_ff;
   logic [VALUE_W-1:0]        out_value_ff;
   logic                      out_last_ff;

   // row-major slot of an element
   function automatic logic [AW-1:0] slot(input logic [IDX_W-1:0] row,
                                          input logic [IDX_W-1:0] col);
      logic [CALC_W-1:0] s;
      s = CALC_W'(row) * CALC_W'(MAX_DIM) + CALC_W'(col);
      return s[AW-1:0];
   endfunction

   assign wr_addr   = slot(cmd.wr_row, cmd.wr_col);
   assign rd_addr_a = slot(cmd.rd_row, cmd.rd_inner);
   assign rd_addr_b = slot(cmd.rd_inner, cmd.rd_col);

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         a_mem[wr_addr] <= wr_value;
      end
      if (cmd.rd_en) begin
         a_ff <= a_mem[rd_addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_b) begin
         b_mem[wr_addr] <= wr_value;
      end
      if (cmd.rd_en) begin
         b_ff <= b_mem[rd_addr_b];
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      prod_ff <= a_ff * b_ff;
   end

   // accumulate stage, wide enough for the exact sum
   always_comb begin
      acc_in = acc_ff;
      if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else if (cmd.acc_clear) begin
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // clamp to the signed 64-bit range
   always_comb begin
      if ((&acc_ff[ACC_W-1:VALUE_W-1]) || !(|acc_ff[ACC_W-1:VALUE_W-1])) begin
         sat_value = acc_ff[VALUE_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
      end
   end

   assign sts.out_free = !out_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.rd_en;
         prod_vld_ff <= rd_vld_ff;
         if (cmd.out_load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_row_ff   <= cmd.rd_row;
         out_col_ff   <= cmd.rd_col;
         out_value_ff <= sat_value;
         out_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_row    = out_row_ff;
   assign rsp_col    = out_col_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

### sv/matrix_multiply_engine_top.sv
// top level of the matrix multiply engine: stream ports, configuration port,
// controller and datapath; uses mme_pkg, mme_ctrl and mme_dpath
//
// usage
//   req channel: one word per request. tuser holds the kind: load an element
//   of the first matrix, load an element of the second matrix, or compute.
//   a load gives no result; loads outside the sizes set in the size
//   registers, and the unused kind, are dropped.
//   a compute streams out_rows x out_cols result words on the rsp channel in
//   row-major order, tlast on the final one. each result element streams
//   one inner product term per cycle through the single multiply-accumulate
//   unit (one read port per store) and its store read, multiply and
//   accumulate stages. req_tready is low while a compute runs.
//   the result sits in an output register: the block takes the next request
//   while the final result still waits; a stalled rsp_tready holds the
//   sequencer before the next element is placed.
//   csr channel: always ready, index selects out_rows, inner_size, out_cols;
//   write only while the block is idle.
//   reset: synchronous, sizes go to 8, no result pending; the stores keep
//   their contents and must be written before they are used.
`default_nettype none

module matrix_multiply_engine_top #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // elem_row [2:0], elem_col [5:3], elem_value [37:6], zero pad [39:38]
   input  wire logic [mme_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_type [1:0]
   input  wire logic [mme_pkg::TYPE_W-1:0]          req_tuser,
   // result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // out_row [2:0], out_col [5:3], out_value [69:6], zero pad [71:70]
   output logic [mme_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   output logic                                     rsp_tlast,
   // configuration channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mme_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mme_pkg::SIZE_W-1:0]          csr_data
);
   import mme_pkg::*;

   mme_cmd_type cmd;
   mme_sts_type sts;

   // unpack the request word
   logic [IDX_W-1:0]  req_row;
   logic [IDX_W-1:0]  req_col;
   logic [ELEM_W-1:0] req_value;

   assign req_row   = req_tdata[IDX_W-1:0];
   assign req_col   = req_tdata[2*IDX_W-1:IDX_W];
   assign req_value = req_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];

   // result fields
   logic [IDX_W-1:0]   rsp_row;
   logic [IDX_W-1:0]   rsp_col;
   logic [VALUE_W-1:0] rsp_value;

   assign rsp_tdata = {{(RSP_TDATA_W-VALUE_W-2*IDX_W){1'b0}}, rsp_value, rsp_col, rsp_row};

   // sequencer and size registers
   mme_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .req_row    (req_row),
      .req_col    (req_col),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

   // stores, multiply-accumulate pipe and output register
   mme_dpath #(
      .MAX_DIM (MAX_DIM)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .wr_value   (req_value),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_row    (rsp_row),
      .rsp_col    (rsp_col),
      .rsp_value  (rsp_value),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
